// ----- rtl/smpv_pkg.sv -----
// Shared constants, types and gain helpers for the stereo pan/volume mixer.
package smpv_pkg;

    localparam int SOURCES      = 4;
    localparam int SAMPLE_BITS  = 16;
    localparam int SLOTS_PACKED = 4;
    localparam int LANE_LIMIT   = (SOURCES < SLOTS_PACKED) ? SOURCES : SLOTS_PACKED;

    localparam int VOL_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W + 1;
    localparam int ACC_W       = PROD_W + $clog2(SOURCES) + 1;
    localparam int MST_W       = VOL_W + 1;
    localparam int MIX_W       = ACC_W + MST_W;
    localparam int FRAC_SHIFT  = 30;
    localparam int PAN_SHIFT   = 14;
    localparam int LATENCY     = 5;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [VOL_W-1:0]        UNITY_Q15 = VOL_W'(32768);
    localparam logic signed [VOL_W-1:0] PAN_ONE   = VOL_W'(16384);
    localparam logic signed [VOL_W-1:0] PAN_MONE  = -PAN_ONE;

    localparam logic [63:0] VOLUMES_RESET = 64'h6666_6666_6666_6666;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENGINE_COUNT   = 3'd0,
        REG_ENGINE_VOLUMES = 3'd1,
        REG_ENGINE_PANS    = 3'd2,
        REG_MASTER_VOLUME  = 3'd3,
        REG_SOLO_ENABLE    = 3'd4,
        REG_SOLO_ENGINE    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic enable;
        logic solo;
    } lane_ctl_t;

    function automatic logic [VOL_W-1:0] clamp_volume(input logic [VOL_W-1:0] v);
        logic [VOL_W-1:0] r;
        r = (v > UNITY_Q15) ? UNITY_Q15 : v;
        return r;
    endfunction

    function automatic logic signed [VOL_W-1:0] clamp_pan(input logic [VOL_W-1:0] v);
        logic signed [VOL_W-1:0] p;
        logic signed [VOL_W-1:0] r;
        p = $signed(v);
        if (p < PAN_MONE)
            r = PAN_MONE;
        else if (p > PAN_ONE)
            r = PAN_ONE;
        else
            r = p;
        return r;
    endfunction

endpackage

// ----- rtl/smpv_lane.sv -----
// One source lane: pan/volume gains, then sample times gain for both channels.
module smpv_lane
    import smpv_pkg::*;
(
    input  logic                            clk,
    input  lane_ctl_t                       ctl,
    input  logic [VOL_W-1:0]                volume,
    input  logic [VOL_W-1:0]                pan,
    input  logic signed [SAMPLE_BITS-1:0]   sample_left,
    input  logic signed [SAMPLE_BITS-1:0]   sample_right,
    output logic signed [PROD_W-1:0]        product_left,
    output logic signed [PROD_W-1:0]        product_right
);

    logic [VOL_W-1:0]               vol_c;
    logic signed [VOL_W-1:0]        pan_c;
    logic signed [VOL_W:0]          fac_l_s;
    logic signed [VOL_W:0]          fac_r_s;
    logic [30:0]                    mul_l;
    logic [30:0]                    mul_r;
    logic [30:0]                    rnd_l;
    logic [30:0]                    rnd_r;
    logic [GAIN_W-1:0]              pan_gain_l;
    logic [GAIN_W-1:0]              pan_gain_r;

    logic [GAIN_W-1:0]              gain_l_reg, gain_l_next;
    logic [GAIN_W-1:0]              gain_r_reg, gain_r_next;
    logic signed [SAMPLE_BITS-1:0]  smp_l_reg;
    logic signed [SAMPLE_BITS-1:0]  smp_r_reg;
    logic signed [PROD_W-1:0]       prod_l_reg, prod_l_next;
    logic signed [PROD_W-1:0]       prod_r_reg, prod_r_next;

    always_comb
    begin
        vol_c   = clamp_volume(volume);
        pan_c   = clamp_pan(pan);
        fac_l_s = (VOL_W+1)'(PAN_ONE) - (VOL_W+1)'(pan_c);
        fac_r_s = (VOL_W+1)'(PAN_ONE) + (VOL_W+1)'(pan_c);
        mul_l   = 31'(vol_c) * 31'(fac_l_s[VOL_W-1:0]);
        mul_r   = 31'(vol_c) * 31'(fac_r_s[VOL_W-1:0]);
        rnd_l   = (mul_l + 31'd8192) >> PAN_SHIFT;
        rnd_r   = (mul_r + 31'd8192) >> PAN_SHIFT;
        // attenuate only the side the source is panned away from
        pan_gain_l = pan_c[VOL_W-1] ? vol_c : rnd_l[GAIN_W-1:0];
        pan_gain_r = (!pan_c[VOL_W-1] && (pan_c != '0)) ? vol_c : rnd_r[GAIN_W-1:0];
    end

    always_comb
    begin
        if (!ctl.enable)
        begin
            gain_l_next = '0;
            gain_r_next = '0;
        end
        else if (ctl.solo)
        begin
            gain_l_next = vol_c;
            gain_r_next = vol_c;
        end
        else
        begin
            gain_l_next = pan_gain_l;
            gain_r_next = pan_gain_r;
        end
    end

    assign prod_l_next = PROD_W'(smp_l_reg) * PROD_W'($signed({1'b0, gain_l_reg}));
    assign prod_r_next = PROD_W'(smp_r_reg) * PROD_W'($signed({1'b0, gain_r_reg}));

    always_ff @(posedge clk)
    begin
        gain_l_reg <= gain_l_next;
        gain_r_reg <= gain_r_next;
        smp_l_reg  <= sample_left;
        smp_r_reg  <= sample_right;
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
    end

    assign product_left  = prod_l_reg;
    assign product_right = prod_r_reg;

endmodule

// ----- rtl/smpv_merge.sv -----
// Merging stage: sum the lane products, apply master volume, round and saturate.
module smpv_merge
    import smpv_pkg::*;
(
    input  logic                            clk,
    input  logic signed [PROD_W-1:0]        product_left  [SOURCES],
    input  logic signed [PROD_W-1:0]        product_right [SOURCES],
    input  logic [VOL_W-1:0]                master_volume,
    output logic signed [SAMPLE_BITS-1:0]   mix_left,
    output logic signed [SAMPLE_BITS-1:0]   mix_right
);

    localparam logic signed [MIX_W-1:0] SAT_HI     = MIX_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [MIX_W-1:0] SAT_LO     = -SAT_HI - MIX_W'(1);
    localparam logic signed [MIX_W-1:0] ROUND_BIAS = MIX_W'(64'd1 << (FRAC_SHIFT - 1));

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [MIX_W-1:0] x
    );
        logic signed [MIX_W-1:0] r;
        logic signed [SAMPLE_BITS-1:0] s;
        r = (x + ROUND_BIAS) >>> FRAC_SHIFT;
        if (r > SAT_HI)
            s = SAT_HI[SAMPLE_BITS-1:0];
        else if (r < SAT_LO)
            s = SAT_LO[SAMPLE_BITS-1:0];
        else
            s = r[SAMPLE_BITS-1:0];
        return s;
    endfunction

    logic signed [MST_W-1:0]        mst;
    logic signed [ACC_W-1:0]        sum_l_reg, sum_l_next;
    logic signed [ACC_W-1:0]        sum_r_reg, sum_r_next;
    logic signed [MIX_W-1:0]        mul_l_reg, mul_l_next;
    logic signed [MIX_W-1:0]        mul_r_reg, mul_r_next;
    logic signed [SAMPLE_BITS-1:0]  out_l_reg, out_l_next;
    logic signed [SAMPLE_BITS-1:0]  out_r_reg, out_r_next;

    always_comb
    begin
        sum_l_next = '0;
        sum_r_next = '0;
        for (int i = 0; i < SOURCES; i++)
        begin
            sum_l_next = sum_l_next + ACC_W'(product_left[i]);
            sum_r_next = sum_r_next + ACC_W'(product_right[i]);
        end
    end

    assign mst        = $signed({1'b0, clamp_volume(master_volume)});
    assign mul_l_next = MIX_W'(sum_l_reg) * MIX_W'(mst);
    assign mul_r_next = MIX_W'(sum_r_reg) * MIX_W'(mst);
    assign out_l_next = round_sat(mul_l_reg);
    assign out_r_next = round_sat(mul_r_reg);

    always_ff @(posedge clk)
    begin
        sum_l_reg <= sum_l_next;
        sum_r_reg <= sum_r_next;
        mul_l_reg <= mul_l_next;
        mul_r_reg <= mul_r_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
    end

    assign mix_left  = out_l_reg;
    assign mix_right = out_r_reg;

endmodule

// ----- rtl/stereo_mixer_pan_volume.sv -----
// Top level of the stereo mixer: configuration registers, source lanes and merge.
// Done and the result come up together, once a frame has passed the gain, product, sum,
// master product and round/saturate registers in that order.
// Throughput: one frame per cycle; busy stays low, the pipeline never stalls.
// Reset: configuration returns to its defaults and the pipeline valid bits clear.
module stereo_mixer_pan_volume
    import smpv_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            cfg_write,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]           cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]   src0_left,
    input  logic signed [SAMPLE_BITS-1:0]   src0_right,
    input  logic signed [SAMPLE_BITS-1:0]   src1_left,
    input  logic signed [SAMPLE_BITS-1:0]   src1_right,
    input  logic signed [SAMPLE_BITS-1:0]   src2_left,
    input  logic signed [SAMPLE_BITS-1:0]   src2_right,
    input  logic signed [SAMPLE_BITS-1:0]   src3_left,
    input  logic signed [SAMPLE_BITS-1:0]   src3_right,
    input  logic                            block_end_in,
    output logic                            done,
    output logic signed [SAMPLE_BITS-1:0]   mix_left,
    output logic signed [SAMPLE_BITS-1:0]   mix_right,
    output logic                            block_end_out
);

    logic [2:0]             engine_count_reg;
    logic [63:0]            engine_volumes_reg;
    logic [63:0]            engine_pans_reg;
    logic [VOL_W-1:0]       master_volume_reg;
    logic                   solo_enable_reg;
    logic [1:0]             solo_engine_reg;

    logic [LATENCY-1:0]     valid_reg, valid_next;
    logic [LATENCY-1:0]     end_reg, end_next;
    logic                   accept;

    logic signed [SAMPLE_BITS-1:0]  smp_l [SOURCES];
    logic signed [SAMPLE_BITS-1:0]  smp_r [SOURCES];
    logic signed [PROD_W-1:0]       prod_l [SOURCES];
    logic signed [PROD_W-1:0]       prod_r [SOURCES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign smp_l[0] = src0_left;
    assign smp_r[0] = src0_right;
    assign smp_l[1] = src1_left;
    assign smp_r[1] = src1_right;
    assign smp_l[2] = src2_left;
    assign smp_r[2] = src2_right;
    assign smp_l[3] = src3_left;
    assign smp_r[3] = src3_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            engine_count_reg   <= '0;
            engine_volumes_reg <= VOLUMES_RESET;
            engine_pans_reg    <= '0;
            master_volume_reg  <= UNITY_Q15;
            solo_enable_reg    <= 1'b0;
            solo_engine_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENGINE_COUNT:   engine_count_reg   <= cfg_data[2:0];
                REG_ENGINE_VOLUMES: engine_volumes_reg <= cfg_data;
                REG_ENGINE_PANS:    engine_pans_reg    <= cfg_data;
                REG_MASTER_VOLUME:  master_volume_reg  <= cfg_data[VOL_W-1:0];
                REG_SOLO_ENABLE:    solo_enable_reg    <= cfg_data[0];
                REG_SOLO_ENGINE:    solo_engine_reg    <= cfg_data[1:0];
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    assign valid_next = {valid_reg[LATENCY-2:0], accept};
    assign end_next   = {end_reg[LATENCY-2:0], block_end_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            end_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            end_reg   <= end_next;
        end
    end

    for (genvar i = 0; i < SOURCES; i++)
    begin : g_lane
        lane_ctl_t          ctl;
        logic [VOL_W-1:0]   vol_field;
        logic [VOL_W-1:0]   pan_field;

        if (i < SLOTS_PACKED)
        begin : g_slot
            assign vol_field = engine_volumes_reg[16*i +: 16];
            assign pan_field = engine_pans_reg[16*i +: 16];
        end
        else
        begin : g_noslot
            assign vol_field = '0;
            assign pan_field = '0;
        end

        // solo ignores the active count; sources without a slot never pass
        assign ctl = '{enable: (i < LANE_LIMIT) &&
                               (solo_enable_reg ? (32'(solo_engine_reg) == i)
                                                : (32'(engine_count_reg) > i)),
                       solo:   solo_enable_reg};

        smpv_lane u_lane (
            .clk           (clk),
            .ctl           (ctl),
            .volume        (vol_field),
            .pan           (pan_field),
            .sample_left   (smp_l[i]),
            .sample_right  (smp_r[i]),
            .product_left  (prod_l[i]),
            .product_right (prod_r[i])
        );
    end

    smpv_merge u_merge (
        .clk           (clk),
        .product_left  (prod_l),
        .product_right (prod_r),
        .master_volume (master_volume_reg),
        .mix_left      (mix_left),
        .mix_right     (mix_right)
    );

    assign done          = valid_reg[LATENCY-1];
    assign block_end_out = end_reg[LATENCY-1];

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for the stereo pan/volume mixer: register sweeps and frame streams.
module testbench;
    import smpv_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        ST_FRAME,
        ST_WRITE,
        ST_DRAIN
    } step_kind_t;

    typedef struct packed {
        logic [SOURCES-1:0][SAMPLE_BITS-1:0] left;
        logic [SOURCES-1:0][SAMPLE_BITS-1:0] right;
        logic                                block_end;
    } frame_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic                   block_end;
    } mix_t;

    typedef struct {
        step_kind_t              kind;
        int                      gap;
        frame_t                  frame;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic signed [SAMPLE_BITS-1:0] src0_left = '0;
    logic signed [SAMPLE_BITS-1:0] src0_right = '0;
    logic signed [SAMPLE_BITS-1:0] src1_left = '0;
    logic signed [SAMPLE_BITS-1:0] src1_right = '0;
    logic signed [SAMPLE_BITS-1:0] src2_left = '0;
    logic signed [SAMPLE_BITS-1:0] src2_right = '0;
    logic signed [SAMPLE_BITS-1:0] src3_left = '0;
    logic signed [SAMPLE_BITS-1:0] src3_right = '0;
    logic block_end_in = 1'b0;
    logic busy;
    logic done;
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;
    logic block_end_out;

    // Shadow of the mixer registers, reset values as after rst_n
    logic [2:0]  cur_count = 3'd0;
    logic [63:0] cur_volumes = VOLUMES_RESET;
    logic [63:0] cur_pans = 64'd0;
    logic [15:0] cur_master = UNITY_Q15;
    logic        cur_solo = 1'b0;
    logic [1:0]  cur_solo_src = 2'd0;

    step_t  pending[$];
    mix_t   mix_due[$];
    frame_t on_bus = '0;
    int     gap_left = 0;
    int     frames_queued = 0;
    int     frames_taken = 0;
    int     mixes_checked = 0;
    int     writes_issued = 0;
    int     solo_frames = 0;
    int     clipped = 0;
    int     errors = 0;
    int     cycles = 0;

    stereo_mixer_pan_volume DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .src0_left     (src0_left),
        .src0_right    (src0_right),
        .src1_left     (src1_left),
        .src1_right    (src1_right),
        .src2_left     (src2_left),
        .src2_right    (src2_right),
        .src3_left     (src3_left),
        .src3_right    (src3_right),
        .block_end_in  (block_end_in),
        .done          (done),
        .mix_left      (mix_left),
        .mix_right     (mix_right),
        .block_end_out (block_end_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s", what);
    endtask

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENGINE_COUNT:   cur_count = data[2:0];
            REG_ENGINE_VOLUMES: cur_volumes = data;
            REG_ENGINE_PANS:    cur_pans = data;
            REG_MASTER_VOLUME:  cur_master = data[15:0];
            REG_SOLO_ENABLE:    cur_solo = data[0];
            REG_SOLO_ENGINE:    cur_solo_src = data[1:0];
            default: ;
        endcase
    endfunction

    function automatic longint lane_volume(input int i);
        logic [15:0] v;
        v = cur_volumes[16*i +: 16];
        return (v > UNITY_Q15) ? longint'(UNITY_Q15) : longint'(v);
    endfunction

    // Round half up at bit 30, then clip to the sample range
    function automatic logic [SAMPLE_BITS-1:0] to_sample(input longint x);
        longint y;
        y = (x + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (y > 32767) begin
            clipped++;
            y = 32767;
        end else if (y < -32768) begin
            clipped++;
            y = -32768;
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    function automatic mix_t pan_mix(input frame_t f);
        longint mst;
        longint accl;
        longint accr;
        longint vol;
        longint pan;
        longint gl;
        longint gr;
        logic signed [15:0] raw_pan;
        int n;
        mix_t r;
        mst = (cur_master > UNITY_Q15) ? longint'(UNITY_Q15) : longint'(cur_master);
        accl = 0;
        accr = 0;
        if (cur_solo) begin
            solo_frames++;
            if (int'(cur_solo_src) < LANE_LIMIT) begin
                vol = lane_volume(int'(cur_solo_src)) * mst;
                accl = longint'($signed(f.left[cur_solo_src])) * vol;
                accr = longint'($signed(f.right[cur_solo_src])) * vol;
            end
        end else begin
            n = (int'(cur_count) > LANE_LIMIT) ? LANE_LIMIT : int'(cur_count);
            for (int i = 0; i < n; i++) begin
                vol = lane_volume(i);
                raw_pan = cur_pans[16*i +: 16];
                pan = longint'(raw_pan);
                if (pan > longint'(PAN_ONE))
                    pan = longint'(PAN_ONE);
                if (pan < -longint'(PAN_ONE))
                    pan = -longint'(PAN_ONE);
                gl = vol;
                gr = vol;
                // linear law: only the far side is attenuated
                if (pan >= 0)
                    gl = (vol * (longint'(PAN_ONE) - pan) + (64'sd1 <<< (PAN_SHIFT - 1)))
                         >>> PAN_SHIFT;
                if (pan <= 0)
                    gr = (vol * (longint'(PAN_ONE) + pan) + (64'sd1 <<< (PAN_SHIFT - 1)))
                         >>> PAN_SHIFT;
                accl += longint'($signed(f.left[i])) * gl;
                accr += longint'($signed(f.right[i])) * gr;
            end
            accl *= mst;
            accr *= mst;
        end
        r.left = to_sample(accl);
        r.right = to_sample(accr);
        r.block_end = f.block_end;
        return r;
    endfunction

    function automatic logic [15:0] pick_sample(input int style);
        logic [15:0] s;
        case (style)
            0: s = 16'($urandom);
            1:
            begin
                case ($urandom_range(0, 3))
                    0: s = 16'h7FFF;
                    1: s = 16'h8000;
                    2: s = 16'h0000;
                    default: s = 16'hFFFF;
                endcase
            end
            default: s = 16'(int'($urandom_range(0, 1023)) - 512);
        endcase
        return s;
    endfunction

    function automatic frame_t random_frame(input int style);
        frame_t f;
        for (int i = 0; i < SOURCES; i++) begin
            f.left[i] = pick_sample(style);
            f.right[i] = pick_sample(style);
        end
        f.block_end = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    function automatic frame_t flat_frame(input logic [15:0] v, input logic be);
        frame_t f;
        for (int i = 0; i < SOURCES; i++) begin
            f.left[i] = v;
            f.right[i] = v;
        end
        f.block_end = be;
        return f;
    endfunction

    task automatic add_frame(input frame_t f, input int gap);
        step_t s;
        s.kind = ST_FRAME;
        s.gap = gap;
        s.frame = f;
        s.idx = '0;
        s.data = '0;
        pending.push_back(s);
        frames_queued++;
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s.kind = ST_WRITE;
        s.gap = 0;
        s.frame = '0;
        s.idx = idx;
        s.data = data;
        pending.push_back(s);
    endtask

    task automatic add_drain();
        step_t s;
        s.kind = ST_DRAIN;
        s.gap = 0;
        s.frame = '0;
        s.idx = '0;
        s.data = '0;
        pending.push_back(s);
    endtask

    function automatic logic [15:0] pick_volume();
        case ($urandom_range(0, 9))
            6: return 16'h8000;
            7: return 16'h0000;
            8, 9: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_pan();
        case ($urandom_range(0, 9))
            6: return 16'h4000;
            7: return 16'hC000;
            8, 9: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Rewrite every register; upper data bits stay random to exercise masking
    task automatic random_setup();
        logic [63:0] d;
        d = {$urandom, $urandom};
        d[2:0] = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(1, 4));
        add_write(REG_ENGINE_COUNT, d);
        for (int i = 0; i < 4; i++)
            d[16*i +: 16] = pick_volume();
        add_write(REG_ENGINE_VOLUMES, d);
        for (int i = 0; i < 4; i++)
            d[16*i +: 16] = pick_pan();
        add_write(REG_ENGINE_PANS, d);
        d = {$urandom, $urandom};
        d[15:0] = pick_volume();
        add_write(REG_MASTER_VOLUME, d);
        d = {$urandom, $urandom};
        d[0] = ($urandom_range(0, 4) == 0);
        add_write(REG_SOLO_ENABLE, d);
        add_write(REG_SOLO_ENGINE, {$urandom, $urandom});
        if ($urandom_range(0, 5) == 0)
            add_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
    endtask

    // Driver: one transfer per edge when start is high and busy low
    always @(posedge clk or negedge rst_n)
    begin : driver
        step_t head;
        logic  go;
        logic  wr;
        if (!rst_n) begin
            start <= 1'b0;
            cfg_write <= 1'b0;
        end else begin
            go = 1'b0;
            wr = 1'b0;
            head = '{kind: ST_DRAIN, gap: 0, frame: '0, idx: '0, data: '0};
            if (start && !busy) begin
                mix_due.push_back(pan_mix(on_bus));
                frames_taken++;
            end
            if (start && busy) begin
                go = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending.size() > 0) begin
                head = pending[0];
                case (head.kind)
                    ST_FRAME:
                    begin
                        if (head.gap > 0) begin
                            gap_left = head.gap - 1;
                            pending[0].gap = 0;
                        end else begin
                            on_bus = head.frame;
                            go = 1'b1;
                            void'(pending.pop_front());
                        end
                    end
                    ST_WRITE:
                    begin
                        // registers change only with the pipeline empty
                        if (frames_taken == mixes_checked) begin
                            wr = 1'b1;
                            apply_reg_write(head.idx, head.data);
                            writes_issued++;
                            void'(pending.pop_front());
                        end
                    end
                    default:
                    begin
                        if (frames_taken == mixes_checked)
                            void'(pending.pop_front());
                    end
                endcase
            end
            start <= go;
            cfg_write <= wr;
            if (wr) begin
                cfg_index <= head.idx;
                cfg_data <= head.data;
            end
            src0_left <= on_bus.left[0];
            src0_right <= on_bus.right[0];
            src1_left <= on_bus.left[1];
            src1_right <= on_bus.right[1];
            src2_left <= on_bus.left[2];
            src2_right <= on_bus.right[2];
            src3_left <= on_bus.left[3];
            src3_right <= on_bus.right[3];
            block_end_in <= on_bus.block_end;
        end
    end

    // Monitor: each done pulse is one result transfer
    always @(posedge clk or negedge rst_n)
    begin : monitor
        mix_t due;
        if (!rst_n) begin
            mixes_checked <= 0;
        end else if (done) begin
            if (mix_due.size() == 0) begin
                report_mismatch("result arrived with none outstanding");
            end else begin
                due = mix_due.pop_front();
                if (mix_left !== due.left)
                    report_mismatch($sformatf("frame %0d mix_left %0d, predicted %0d",
                        mixes_checked, mix_left, $signed(due.left)));
                if (mix_right !== due.right)
                    report_mismatch($sformatf("frame %0d mix_right %0d, predicted %0d",
                        mixes_checked, mix_right, $signed(due.right)));
                if (block_end_out !== due.block_end)
                    report_mismatch($sformatf("frame %0d block_end_out %b, predicted %b",
                        mixes_checked, block_end_out, due.block_end));
                mixes_checked <= mixes_checked + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames outstanding", cycles, mix_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n;
        int gap;
        logic idle_phase;

        // reset config has no active source: silence expected
        add_frame(flat_frame(16'h7FFF, 1'b1), 0);
        add_write(REG_ENGINE_COUNT, 64'd4);
        add_write(REG_ENGINE_VOLUMES, {4{16'h8000}});
        add_write(REG_ENGINE_PANS, {16'd8192, 16'hC000, 16'h4000, 16'h0000});
        add_write(REG_MASTER_VOLUME, 64'h8000);
        add_frame(flat_frame(16'h7FFF, 1'b0), 0);
        add_frame(flat_frame(16'h8000, 1'b1), 0);
        add_frame(flat_frame(16'h0000, 1'b0), 0);
        add_frame(flat_frame(16'hFFFF, 1'b1), 0);
        add_frame(random_frame(1), 0);
        // gains beyond range: saturate volumes and master, clamp pans
        add_write(REG_ENGINE_VOLUMES, {16'hFFFF, 16'h8001, 16'h0000, 16'h0001});
        add_write(REG_ENGINE_PANS, {16'h7FFF, 16'h8000, 16'hBFFF, 16'hC001});
        add_write(REG_MASTER_VOLUME, 64'hFFFF);
        add_frame(flat_frame(16'h7FFF, 1'b0), 0);
        add_frame(flat_frame(16'h8000, 1'b0), 0);
        add_frame(random_frame(0), 0);
        // count beyond the number of sources
        add_write(REG_ENGINE_COUNT, 64'd7);
        add_frame(random_frame(1), 0);
        add_write(REG_ENGINE_COUNT, 64'd5);
        add_frame(random_frame(0), 0);
        add_write(REG_MASTER_VOLUME, 64'h0);
        add_frame(flat_frame(16'h7FFF, 1'b1), 0);
        // solo with no active source still passes the chosen one
        add_write(REG_MASTER_VOLUME, 64'h8000);
        add_write(REG_ENGINE_COUNT, 64'd0);
        add_write(REG_ENGINE_VOLUMES, {16'h8000, 16'h4000, 16'hFFFF, 16'h2000});
        add_write(REG_SOLO_ENABLE, 64'd1);
        for (int s = 0; s < 4; s++) begin
            add_write(REG_SOLO_ENGINE, 64'(s));
            add_frame(random_frame(1), 0);
        end
        // writes to unmapped indices must leave the mix alone
        add_write(REG_SPARE_A, {64{1'b1}});
        add_write(REG_SPARE_B, 64'd0);
        add_frame(flat_frame(16'h8000, 1'b0), 0);
        add_write(REG_SOLO_ENABLE, 64'd0);
        add_frame(flat_frame(16'h7FFF, 1'b1), 0);
        add_drain();

        while (frames_queued < 820) begin
            random_setup();
            idle_phase = $urandom_range(0, 1);
            n = $urandom_range(10, 60);
            repeat (n) begin
                gap = (idle_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
                add_frame(random_frame($urandom_range(0, 9) < 6 ? 0 :
                                       ($urandom_range(0, 1) ? 1 : 2)), gap);
                if ($urandom_range(0, 40) == 0)
                    add_drain();
            end
        end
        // closing stretch at full rate
        random_setup();
        repeat (100)
            add_frame(random_frame($urandom_range(0, 2)), 0);

        do
            @(negedge clk);
        while (pending.size() != 0 || start || frames_taken != mixes_checked);
        repeat (LATENCY + 4) @(negedge clk);

        if (mix_due.size() != 0)
            report_mismatch($sformatf("%0d predicted frames never returned", mix_due.size()));
        $display("covered %0d frames (%0d solo, %0d clipped channels) over %0d register writes",
                 frames_taken, solo_frames, clipped, writes_issued);
        $display("%0d mismatches in %0d cycles", errors, cycles);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/smpv_pkg.sv
rtl/smpv_lane.sv
rtl/smpv_merge.sv
rtl/stereo_mixer_pan_volume.sv
tb/sv/testbench.sv
